FILE: sv/tbe_pkg.sv
// ----------------------------------------------------------------------------
// tbe_pkg
// Types, style codes, character constants and the per-byte escape function
// shared by the text byte escape encoder.
// ----------------------------------------------------------------------------
package tbe_pkg;

	localparam logic [2:0] STYLE_LITERAL    = 3'd0;
	localparam logic [2:0] STYLE_HIDE       = 3'd1;
	localparam logic [2:0] STYLE_ESCAPE     = 3'd2;
	localparam logic [2:0] STYLE_C          = 3'd3;
	localparam logic [2:0] STYLE_LOCALE     = 3'd4;
	localparam logic [2:0] STYLE_SQ_BSLASH  = 3'd5;
	localparam logic [2:0] STYLE_CTRL_QMARK = 3'd6;
	localparam logic [2:0] STYLE_CTRL_CARET = 3'd7;

	localparam logic REG_QUOTE_STYLE = 1'b0;
	localparam logic REG_HIGH_BIT    = 1'b1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_FLIP = 8'h40;

	localparam int MAX_OUT = 6;

	typedef struct packed {
		logic [7:0]      quote;
		logic            open;
		logic            close;
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} body_t;

	function automatic logic is_printable(input logic [7:0] c);
		return (c >= CH_SPACE) && (c <= CH_TILDE);
	endfunction

	function automatic logic [7:0] named_escape(input logic [7:0] c);
		logic [7:0] n;
		case (c)
			8'h07:   n = 8'h61;
			8'h08:   n = 8'h62;
			8'h0C:   n = 8'h66;
			8'h0A:   n = 8'h6E;
			8'h0D:   n = 8'h72;
			8'h09:   n = 8'h74;
			8'h0B:   n = 8'h76;
			default: n = CH_NUL;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] quote_of(input logic [2:0] style);
		logic [7:0] q;
		case (style)
			STYLE_C:                       q = CH_DQ;
			STYLE_LOCALE, STYLE_SQ_BSLASH: q = CH_SQ;
			default:                       q = CH_NUL;
		endcase
		return q;
	endfunction

	// Bytes produced by one text byte, without any framing quotes.
	function automatic body_t body_of(input logic [7:0] c, input logic has,
	                                  input logic [2:0] style, input logic high_bit);
		body_t      b;
		logic [7:0] n;
		logic       pr;
		logic       esc;
		b       = '0;
		n       = named_escape(c);
		pr      = is_printable(c);
		esc     = (c == CH_BSLASH) || (c == CH_SPACE && style == STYLE_ESCAPE) ||
		          (c == CH_DQ && style == STYLE_C) || (c == CH_SQ && style == STYLE_LOCALE);
		b.quote = quote_of(style);
		case (style)
			STYLE_LITERAL: begin
				b.len = 3'd1; b.bytes[0] = c;
			end
			STYLE_HIDE: begin
				b.len = 3'd1; b.bytes[0] = pr ? c : CH_QMARK;
			end
			STYLE_ESCAPE, STYLE_C, STYLE_LOCALE: begin
				if (n != CH_NUL) begin
					b.len = 3'd2; b.bytes[0] = CH_BSLASH; b.bytes[1] = n;
				end else if (esc) begin
					b.len = 3'd2; b.bytes[0] = CH_BSLASH; b.bytes[1] = c;
				end else if (pr) begin
					b.len = 3'd1; b.bytes[0] = c;
				end else begin
					b.len      = 3'd4;
					b.bytes[0] = CH_BSLASH;
					b.bytes[1] = {6'b001100, c[7:6]};
					b.bytes[2] = {5'b00110, c[5:3]};
					b.bytes[3] = {5'b00110, c[2:0]};
				end
			end
			STYLE_SQ_BSLASH: begin
				if (c == CH_SQ || c == CH_BSLASH) begin
					b.len = 3'd2; b.bytes[0] = CH_BSLASH; b.bytes[1] = c;
				end else begin
					b.len = 3'd1; b.bytes[0] = c;
				end
			end
			default: begin
				if (pr || (high_bit && c[7])) begin
					b.len = 3'd1; b.bytes[0] = c;
				end else if (style == STYLE_CTRL_QMARK) begin
					b.len = 3'd1; b.bytes[0] = CH_QMARK;
				end else begin
					b.len      = 3'd2;
					b.bytes[0] = CH_CARET;
					b.bytes[1] = (c == CH_DEL) ? CH_QMARK : (c ^ CTRL_FLIP);
				end
			end
		endcase
		if (!has) begin
			b.len = 3'd0;
		end
		return b;
	endfunction

endpackage

FILE: sv/tbe_front.sv
// ----------------------------------------------------------------------------
// tbe_front
// Input register stage and classification stage: each text byte is turned
// into its escaped body plus the framing quote flags.
// ----------------------------------------------------------------------------
module tbe_front import tbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       has_byte,
	input  logic       string_start,
	input  logic       string_end,
	input  logic [2:0] quote_style,
	input  logic       upper_printable,
	output logic       body_valid,
	output body_t      body,
	input  logic       body_take
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       start_s1;
	logic       end_s1;
	logic       valid_s2;
	body_t      body_s2;
	body_t      body_c;
	logic       s1_free;
	logic       s2_free;

	assign s2_free    = !valid_s2 || body_take;
	assign s1_free    = !valid_s1 || s2_free;
	assign text_stall = !s1_free;

	always_comb begin
		body_c       = body_of(byte_s1, has_s1, quote_style, upper_printable);
		body_c.open  = start_s1 && (body_c.quote != CH_NUL);
		body_c.close = end_s1 && (body_c.quote != CH_NUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= text_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && text_valid) begin
			byte_s1  <= text_byte;
			has_s1   <= has_byte;
			start_s1 <= string_start;
			end_s1   <= string_end;
		end
		if (s2_free && valid_s1) begin
			body_s2 <= body_c;
		end
	end

	assign body_valid = valid_s2;
	assign body       = body_s2;

endmodule

FILE: sv/tbe_serial.sv
// ----------------------------------------------------------------------------
// tbe_serial
// Assembles quotes and body into up to six bytes and shifts them out one per
// cycle from the output stage while quoted_stall is low.
// ----------------------------------------------------------------------------
module tbe_serial import tbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	input  body_t      body,
	output logic       body_take,
	output logic       quoted_valid,
	input  logic       quoted_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic                    valid_s3;
	logic [2:0]              rem_s3;
	logic [MAX_OUT-1:0][7:0] buf_s3;
	logic [MAX_OUT-1:0][7:0] asm_c;
	logic [2:0]              count_c;
	logic [2:0]              j;
	logic                    fire;
	logic                    s3_free;

	assign fire      = valid_s3 && !quoted_stall;
	assign s3_free   = !valid_s3 || (fire && rem_s3 == 3'd1);
	assign body_take = body_valid && s3_free;
	assign count_c   = {2'b00, body.open} + body.len + {2'b00, body.close};

	always_comb begin
		j = 3'd0;
		for (int i = 0; i < MAX_OUT; i++) begin
			j = 3'(i) - {2'b00, body.open};
			if (body.open && i == 0) begin
				asm_c[i] = body.quote;
			end else if (j < body.len) begin
				asm_c[i] = body.bytes[j[1:0]];
			end else begin
				asm_c[i] = body.quote;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			rem_s3   <= 3'd0;
		end else if (body_take) begin
			valid_s3 <= (count_c != 3'd0);
			rem_s3   <= count_c;
		end else if (fire) begin
			valid_s3 <= (rem_s3 != 3'd1);
			rem_s3   <= rem_s3 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (body_take) begin
			buf_s3 <= asm_c;
		end else if (fire) begin
			buf_s3 <= {8'h00, buf_s3[MAX_OUT-1:1]};
		end
	end

	assign quoted_valid = valid_s3;
	assign out_byte     = buf_s3[0];
	assign last_of_run  = (rem_s3 == 3'd1);

endmodule

FILE: sv/text_byte_escape_encoder.sv
// ----------------------------------------------------------------------------
// text_byte_escape_encoder
// Quotes a byte stream in one of eight styles, one text item in, zero to six
// quoted bytes out.
// ----------------------------------------------------------------------------
// The text channel (text_valid/text_stall) takes one item per cycle unless
// text_stall is high: a byte, its has_byte flag and the string start and
// end flags. The quoted channel (quoted_valid/quoted_stall) gives one output
// byte per cycle unless quoted_stall is high, with last_of_run marking the
// final byte of each item. Items that yield no byte are absorbed silently.
// An accepted item passes an input stage, a classification stage and the
// output shift stage before its first byte appears. Throughput is one item
// per cycle while each item yields one byte and the receiver does not stall;
// an item with more bytes holds the output shift stage until its last byte is
// taken and holds the input back through text_stall. The two earlier stages
// keep filling while the output stage works or is stalled by the receiver.
// Reset empties all stages and sets both registers to zero (literal style).
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
// must do so only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module text_byte_escape_encoder import tbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [2:0] cfg_wdata,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       has_byte,
	input  logic       string_start,
	input  logic       string_end,
	output logic       quoted_valid,
	input  logic       quoted_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [2:0] quote_style_q;
	logic       high_bit_q;
	logic       body_valid;
	logic       body_take;
	body_t      body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_style_q <= STYLE_LITERAL;
			high_bit_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUOTE_STYLE: quote_style_q <= cfg_wdata;
				REG_HIGH_BIT:    high_bit_q    <= cfg_wdata[0];
				default:         quote_style_q <= quote_style_q;
			endcase
		end
	end

	tbe_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.text_byte       (text_byte),
		.has_byte        (has_byte),
		.string_start    (string_start),
		.string_end      (string_end),
		.quote_style     (quote_style_q),
		.upper_printable (high_bit_q),
		.body_valid      (body_valid),
		.body            (body),
		.body_take       (body_take)
	);

	tbe_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.body_valid   (body_valid),
		.body         (body),
		.body_take    (body_take),
		.quoted_valid (quoted_valid),
		.quoted_stall (quoted_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	// An item is mid-run: the next cycle must still present a byte.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		quoted_valid && !quoted_stall && !last_of_run |=> quoted_valid)
		else $error("quoted run ended before its last byte");

	// The input only backs up when the output stage holds work.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> quoted_valid)
		else $error("input stalled with an empty output stage");

	// A stalled quoted byte stays on the outputs unchanged.
	a_stalled_byte_stable: assert property (@(posedge clk) disable iff (!arst_n)
		quoted_valid && quoted_stall |=>
		quoted_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("quoted byte changed while stalled");

endmodule

FILE: tb/text_byte_escape_encoder_tb.sv
// ----------------------------------------------------------------------------
// text_byte_escape_encoder_tb
// Self-checking testbench for the text byte escape encoder. A short directed
// sequence covers every quoting style and the corner bytes, then random
// strings run under each register setting. Both channels idle at random, and
// two long receiver hold-offs back up the whole pipeline. Every quoted byte is
// checked in order against a behavioral prediction of the quoting rules.
// ----------------------------------------------------------------------------
module text_byte_escape_encoder_tb;
	import tbe_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       sos;
		logic       eos;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       tail;
	} quoted_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_wr_en    = 1'b0;
	logic       cfg_index    = REG_QUOTE_STYLE;
	logic [2:0] cfg_wdata    = 3'd0;
	logic       text_valid   = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte    = 8'h00;
	logic       has_byte     = 1'b0;
	logic       string_start = 1'b0;
	logic       string_end   = 1'b0;
	logic       quoted_valid;
	logic       quoted_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	text_item_t pending_text[$];
	quoted_t    quoted_exp[$];
	text_item_t next_text;
	quoted_t    want;

	logic [2:0] cur_style    = STYLE_LITERAL;
	logic       cur_high_bit = 1'b0;
	logic       text_fire    = 1'b0;
	logic       tx_idle_en   = 1'b0;
	logic       rx_idle_en   = 1'b0;
	int         tx_gap       = 0;
	int         rx_gap       = 0;
	int         hold_reqs    = 0;
	int         holds_done   = 0;
	int         hold_left    = 0;
	int         text_pushed  = 0;
	int         text_taken   = 0;
	int         mismatches   = 0;

	text_byte_escape_encoder dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void predict_quoted(input text_item_t it);
		logic [7:0] seq[$];
		logic [7:0] q;
		logic [7:0] c;
		logic [7:0] named;
		logic       printable;
		c         = it.data;
		printable = (c >= CH_SPACE) && (c <= CH_TILDE);
		case (cur_style)
			STYLE_C:                       q = CH_DQ;
			STYLE_LOCALE, STYLE_SQ_BSLASH: q = CH_SQ;
			default:                       q = CH_NUL;
		endcase
		case (c)
			8'h07:   named = "a";
			8'h08:   named = "b";
			8'h0C:   named = "f";
			8'h0A:   named = "n";
			8'h0D:   named = "r";
			8'h09:   named = "t";
			8'h0B:   named = "v";
			default: named = CH_NUL;
		endcase
		if (it.sos && q != CH_NUL)
			seq.push_back(q);
		if (it.has) begin
			case (cur_style)
				STYLE_LITERAL: seq.push_back(c);
				STYLE_HIDE:    seq.push_back(printable ? c : CH_QMARK);
				STYLE_ESCAPE, STYLE_C, STYLE_LOCALE: begin
					if (named != CH_NUL) begin
						seq.push_back(CH_BSLASH);
						seq.push_back(named);
					end else if (c == CH_BSLASH || (c == CH_SPACE && cur_style == STYLE_ESCAPE) ||
					             (c == CH_DQ && cur_style == STYLE_C) ||
					             (c == CH_SQ && cur_style == STYLE_LOCALE)) begin
						seq.push_back(CH_BSLASH);
						seq.push_back(c);
					end else if (printable) begin
						seq.push_back(c);
					end else begin
						seq.push_back(CH_BSLASH);
						seq.push_back("0" + c[7:6]);
						seq.push_back("0" + c[5:3]);
						seq.push_back("0" + c[2:0]);
					end
				end
				STYLE_SQ_BSLASH: begin
					if (c == CH_SQ || c == CH_BSLASH)
						seq.push_back(CH_BSLASH);
					seq.push_back(c);
				end
				default: begin
					if (printable || (cur_high_bit && c >= 8'h80)) begin
						seq.push_back(c);
					end else if (cur_style == STYLE_CTRL_QMARK) begin
						seq.push_back(CH_QMARK);
					end else begin
						seq.push_back(CH_CARET);
						seq.push_back((c == CH_DEL) ? CH_QMARK : (c ^ CTRL_FLIP));
					end
				end
			endcase
		end
		if (it.eos && q != CH_NUL)
			seq.push_back(q);
		foreach (seq[k])
			quoted_exp.push_back(quoted_t'{data: seq[k], tail: (k == seq.size() - 1)});
	endfunction

	function automatic logic [7:0] pick_text_byte();
		logic [7:0] corner[16] = '{8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
		                           CH_SPACE, CH_DQ, CH_SQ, CH_BSLASH, CH_TILDE, CH_DEL,
		                           8'h80, 8'hFF};
		case ($urandom_range(0, 3))
			0:       return corner[$urandom_range(0, 15)];
			1:       return 8'($urandom_range(32, 126));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send(input logic [7:0] data, input logic has, input logic sos,
	                    input logic eos);
		pending_text.push_back(text_item_t'{data: data, has: has, sos: sos, eos: eos});
		text_pushed++;
	endtask

	// Mostly well-formed strings; some lose a byte or get scrambled flags.
	task automatic push_string(inout int count);
		int   len;
		logic has;
		logic sos;
		logic eos;
		len = $urandom_range(0, 6);
		if (len == 0) begin
			send(8'($urandom), 1'b0, 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			has = ($urandom_range(0, 11) != 0);
			sos = (i == 0);
			eos = (i == len - 1);
			if ($urandom_range(0, 9) == 0) begin
				sos = 1'($urandom_range(0, 1));
				eos = 1'($urandom_range(0, 1));
			end
			send(pick_text_byte(), has, sos, eos);
			if (has)
				count++;
		end
	endtask

	task automatic write_reg(input logic idx, input logic [2:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_QUOTE_STYLE)
			cur_style = val;
		else
			cur_high_bit = val[0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [2:0] style, input logic high_bit);
		write_reg(REG_QUOTE_STYLE, style);
		write_reg(REG_HIGH_BIT, {2'($urandom_range(0, 3)), high_bit});
	endtask

	// Items that quote to nothing leave no trace in the expected queue, so drain
	// waits on past the pipeline depth before going on.
	task automatic drain();
		while (text_taken != text_pushed || quoted_exp.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!text_valid || text_fire)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				text_valid <= 1'b0;
			end else if (pending_text.size() != 0) begin
				next_text = pending_text.pop_front();
				text_byte    <= next_text.data;
				has_byte     <= next_text.has;
				string_start <= next_text.sos;
				string_end   <= next_text.eos;
				text_valid   <= 1'b1;
				if (tx_idle_en && $urandom_range(0, 5) == 0)
					tx_gap = $urandom_range(1, 16);
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_gap > 0)
			rx_gap--;
		else if (rx_idle_en && $urandom_range(0, 7) == 0)
			rx_gap = $urandom_range(1, 16);
		quoted_stall <= (rx_gap != 0) || (hold_left != 0);
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_reqs) begin
			hold_left  <= 300;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk) begin
		text_fire <= text_valid && !text_stall;
		if (quoted_valid && !quoted_stall) begin
			if (quoted_exp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected quoted byte %h, last_of_run %b", out_byte, last_of_run);
			end else begin
				want = quoted_exp.pop_front();
				if (out_byte !== want.data || last_of_run !== want.tail) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Quoted byte mismatch: expected %h/%b, got %h/%b",
						         want.data, want.tail, out_byte, last_of_run);
				end
			end
		end
		if (text_valid && !text_stall) begin
			predict_quoted(text_item_t'{data: text_byte, has: has_byte,
			                            sos: string_start, eos: string_end});
			text_taken++;
		end
	end

	initial begin
		int count;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(STYLE_C, 1'b0);
		send(8'h00, 1'b0, 1'b1, 1'b1);
		send(CH_DQ, 1'b1, 1'b1, 1'b0);
		send(CH_BSLASH, 1'b1, 1'b0, 1'b0);
		send(8'h00, 1'b1, 1'b0, 1'b0);
		send(8'hFF, 1'b1, 1'b0, 1'b0);
		send(8'h0A, 1'b1, 1'b0, 1'b1);
		send(CH_DEL, 1'b1, 1'b1, 1'b1);
		drain();
		configure(STYLE_ESCAPE, 1'b0);
		send(CH_SPACE, 1'b1, 1'b1, 1'b1);
		send(8'h07, 1'b1, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b1, 1'b1);
		drain();
		configure(STYLE_LOCALE, 1'b0);
		send(CH_SQ, 1'b1, 1'b1, 1'b1);
		send(8'h0D, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_SQ_BSLASH, 1'b0);
		send(CH_BSLASH, 1'b1, 1'b1, 1'b1);
		send(CH_SQ, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_CTRL_CARET, 1'b1);
		send(CH_DEL, 1'b1, 1'b0, 1'b0);
		send(8'h01, 1'b1, 1'b0, 1'b0);
		send(8'h80, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_CTRL_CARET, 1'b0);
		send(8'h80, 1'b1, 1'b0, 1'b0);
		send(8'h1F, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_CTRL_QMARK, 1'b0);
		send(8'h05, 1'b1, 1'b0, 1'b0);
		send(8'hC0, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_HIDE, 1'b0);
		send(8'h80, 1'b1, 1'b0, 1'b0);
		send(8'h41, 1'b1, 1'b0, 1'b0);
		drain();
		configure(STYLE_LITERAL, 1'b0);
		send(8'hFF, 1'b1, 1'b0, 1'b0);
		send(8'h00, 1'b1, 1'b0, 1'b0);
		drain();

		for (int p = 0; p < 18; p++) begin
			if (p < 16)
				configure(3'(p % 8), 1'(p / 8));
			else
				configure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			tx_idle_en <= (p < 15) && ($urandom_range(0, 3) != 0);
			rx_idle_en <= (p < 15) && ($urandom_range(0, 3) != 0);
			if (p == 3 || p == 11)
				hold_reqs++;
			count = 0;
			while (count < 22)
				push_string(count);
			drain();
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
sv/tbe_pkg.sv
sv/tbe_front.sv
sv/tbe_serial.sv
sv/text_byte_escape_encoder.sv
tb/text_byte_escape_encoder_tb.sv
